// File: sv/lru_page_replacement_list_macros.svh
// assertion macros for the lru page list
`ifndef LRU_PAGE_REPLACEMENT_LIST_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_LIST_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define LRUPL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru list check failed");

// next-cycle implication
`define LRUPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru list sequencing check failed");

`endif

// File: sv/lrupl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupl_pkg
// shared types and codes of the lru page list
// ----------------------------------------------------------------------------
package lrupl_pkg;

    localparam int NUM_PAGES_DEF = 32;
    localparam int PAGE_W        = 5;
    localparam int PID_W         = 8;
    localparam int MAX_SLOTS     = 32;

    localparam logic [1:0] OP_TOUCH  = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;
    localparam logic [1:0] OP_EVICT  = 2'd3;

    localparam logic [1:0] KIND_DONE    = 2'd0;
    localparam logic [1:0] KIND_CLEARED = 2'd1;
    localparam logic [1:0] KIND_LRU     = 2'd2;
    localparam logic [1:0] KIND_EMPTY   = 2'd3;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [PID_W-1:0]  pid;
    } entry_t;

endpackage

// File: sv/lru_page_replacement_list.sv
`timescale 1ns / 1ps
// a touch walks the list from rank 0 to its page (to the end for a new page), and a
//   remove makes one memory pass over the list, one rank per cycle; peek/evict read
//   the tail rank, and answer without a memory read when the list is empty
// throughput: one item at a time, busy stays high during the pass; up to DEPTH
// results of a remove come at most one per cycle, the receiver cannot stall them
// reset: list empty (count zero), no memory clearing pass is needed
// ----------------------------------------------------------------------------
// lru_page_replacement_list
// recency-ordered list of resident pages with owning pid, held in one memory
// ----------------------------------------------------------------------------
`include "lru_page_replacement_list_macros.svh"

module lru_page_replacement_list #(
    parameter int NUM_PAGES = lrupl_pkg::NUM_PAGES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   op,
    input  logic [lrupl_pkg::PAGE_W-1:0] page,
    input  logic [lrupl_pkg::PID_W-1:0]  pid,
    output logic                         strobe,
    output logic [1:0]                   kind,
    output logic [lrupl_pkg::PAGE_W-1:0] out_page,
    output logic [lrupl_pkg::PID_W-1:0]  out_pid,
    output logic                         last
);

    // only pages that fit the 5-bit page field can ever be resident
    localparam int DEPTH = (NUM_PAGES < lrupl_pkg::MAX_SLOTS) ? NUM_PAGES
                                                              : lrupl_pkg::MAX_SLOTS;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TOUCH,
        S_REMOVE,
        S_LRU
    } state_t;

    // list memory: entry at rank r, rank 0 is most recent
    lrupl_pkg::entry_t mem [DEPTH];
    lrupl_pkg::entry_t rd_reg;
    logic [IW-1:0]     raddr;
    logic              we;
    logic [IW-1:0]     waddr;
    lrupl_pkg::entry_t wdata;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                r_reg, r_next;         // rank under scan
    logic [CW-1:0]                kept_reg, kept_next;   // compaction write rank
    logic [CW-1:0]                count_reg, count_next;
    logic                         evict_reg, evict_next;
    logic [lrupl_pkg::PAGE_W-1:0] pg_reg, pg_next;
    logic [lrupl_pkg::PID_W-1:0]  pid_reg, pid_next;
    lrupl_pkg::entry_t            hold_reg, hold_next;   // entry carried one rank down
    logic                         pend_reg, pend_next;   // a cleared page waits for its last flag
    logic [lrupl_pkg::PAGE_W-1:0] pend_page_reg, pend_page_next;
    logic                         strobe_reg, strobe_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [lrupl_pkg::PAGE_W-1:0] opage_reg, opage_next;
    logic [lrupl_pkg::PID_W-1:0]  opid_reg, opid_next;
    logic                         last_reg, last_next;
    logic [CW-1:0]                r_inc;
    logic [CW-1:0]                count_dec;

    assign r_inc     = r_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        kept_next      = kept_reg;
        count_next     = count_reg;
        evict_next     = evict_reg;
        pg_next        = pg_reg;
        pid_next       = pid_reg;
        hold_next      = hold_reg;
        pend_next      = pend_reg;
        pend_page_next = pend_page_reg;
        strobe_next    = 1'b0;
        kind_next      = lrupl_pkg::KIND_DONE;
        opage_next     = '0;
        opid_next      = '0;
        last_next      = 1'b0;
        raddr          = r_inc[IW-1:0];
        we             = 1'b0;
        waddr          = r_reg[IW-1:0];
        wdata          = hold_reg;

        case (state_reg)
            S_IDLE:
            begin
                raddr = '0;
                if (start)
                begin
                    pg_next   = page;
                    pid_next  = pid;
                    r_next    = '0;
                    kept_next = '0;
                    pend_next = 1'b0;
                    hold_next = '{page: page, pid: pid};
                    case (op)
                        lrupl_pkg::OP_TOUCH:
                        begin
                            if (32'(page) < 32'(DEPTH))
                            begin
                                state_next = S_TOUCH;
                            end
                            else
                            begin
                                // page out of range: ignored
                                strobe_next = 1'b1;
                                last_next   = 1'b1;
                            end
                        end
                        lrupl_pkg::OP_REMOVE:
                        begin
                            state_next = S_REMOVE;
                        end
                        default:
                        begin
                            evict_next = (op == lrupl_pkg::OP_EVICT);
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                kind_next   = lrupl_pkg::KIND_EMPTY;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                raddr      = count_dec[IW-1:0];
                                state_next = S_LRU;
                            end
                        end
                    endcase
                end
            end

            S_TOUCH:
            begin
                // write the carried entry here, carry what was here one rank down
                we = 1'b1;
                if (r_reg == count_reg)
                begin
                    count_next  = count_reg + 1'b1;
                    state_next  = S_IDLE;
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                end
                else if (rd_reg.page == pg_reg)
                begin
                    state_next  = S_IDLE;
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                end
                else
                begin
                    hold_next = rd_reg;
                    r_next    = r_inc;
                end
            end

            S_REMOVE:
            begin
                waddr = kept_reg[IW-1:0];
                wdata = rd_reg;
                if (r_reg == count_reg)
                begin
                    count_next  = kept_reg;
                    state_next  = S_IDLE;
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    if (pend_reg)
                    begin
                        kind_next  = lrupl_pkg::KIND_CLEARED;
                        opage_next = pend_page_reg;
                        opid_next  = pid_reg;
                    end
                end
                else
                begin
                    r_next = r_inc;
                    if (rd_reg.pid == pid_reg)
                    begin
                        // emit the previous match, keep this one pending
                        if (pend_reg)
                        begin
                            strobe_next = 1'b1;
                            kind_next   = lrupl_pkg::KIND_CLEARED;
                            opage_next  = pend_page_reg;
                            opid_next   = pid_reg;
                        end
                        pend_next      = 1'b1;
                        pend_page_next = rd_reg.page;
                    end
                    else
                    begin
                        we        = 1'b1;
                        kept_next = kept_reg + 1'b1;
                    end
                end
            end

            S_LRU:
            begin
                strobe_next = 1'b1;
                kind_next   = lrupl_pkg::KIND_LRU;
                opage_next  = rd_reg.page;
                opid_next   = rd_reg.pid;
                last_next   = 1'b1;
                state_next  = S_IDLE;
                if (evict_reg)
                begin
                    count_next = count_reg - 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
            pend_reg   <= pend_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        r_reg         <= r_next;
        kept_reg      <= kept_next;
        evict_reg     <= evict_next;
        pg_reg        <= pg_next;
        pid_reg       <= pid_next;
        hold_reg      <= hold_next;
        pend_page_reg <= pend_page_next;
        kind_reg      <= kind_next;
        opage_reg     <= opage_next;
        opid_reg      <= opid_next;
        last_reg      <= last_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign strobe   = strobe_reg;
    assign kind     = kind_reg;
    assign out_page = opage_reg;
    assign out_pid  = opid_reg;
    assign last     = last_reg;

    // the list never holds more pages than slots
    `LRUPL_ASSERT_IMPL(a_count_range, 1'b1, 32'(count_reg) <= 32'(DEPTH))
    // every accepted command either answers next cycle or starts a pass
    `LRUPL_ASSERT_NEXT(a_start_progress, start && !busy, strobe || busy)
    // the final word of a command always frees the block
    `LRUPL_ASSERT_IMPL(a_last_idle, strobe && last, !busy)
    // done and empty words stand alone
    `LRUPL_ASSERT_IMPL(a_single_word,
        strobe && (kind == lrupl_pkg::KIND_DONE || kind == lrupl_pkg::KIND_EMPTY), last)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives touch, remove, peek and evict commands into the lru page list and
// checks every result word against an in-bench model of the recency order
// ----------------------------------------------------------------------------
module tb_top;

    // result word as the list reports it
    typedef struct packed {
        logic [1:0]                   kind;
        logic [lrupl_pkg::PAGE_W-1:0] page;
        logic [lrupl_pkg::PID_W-1:0]  pid;
        logic                         last;
    } word_t;

    // one row of the directed table; chk_kind says if the row has a typed-in kind
    typedef struct packed {
        logic [1:0]                   op;
        logic [lrupl_pkg::PAGE_W-1:0] page;
        logic [lrupl_pkg::PID_W-1:0]  pid;
        logic                         chk_kind;
        logic [1:0]                   exp_kind;
    } row_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_DIRECTED     = 22;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [1:0]                   op;
    logic [lrupl_pkg::PAGE_W-1:0] page;
    logic [lrupl_pkg::PID_W-1:0]  pid;
    logic                         strobe;
    logic [1:0]                   kind;
    logic [lrupl_pkg::PAGE_W-1:0] out_page;
    logic [lrupl_pkg::PID_W-1:0]  out_pid;
    logic                         last;

    // model of the list: pages in recency order, index 0 is most recent
    logic [lrupl_pkg::PAGE_W-1:0] recency_q[$];
    logic [lrupl_pkg::PID_W-1:0]  owner_of[lrupl_pkg::MAX_SLOTS];
    word_t                        pending_words[$];
    int                           err_count;
    int                           idle_cycles;
    bit                           timed_out;
    row_t                         directed[N_DIRECTED];

    lru_page_replacement_list uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .page     (page),
        .pid      (pid),
        .strobe   (strobe),
        .kind     (kind),
        .out_page (out_page),
        .out_pid  (out_pid),
        .last     (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        err_count++;
        $display({"mismatch %s at %0t: got kind %0d page %0d pid %0d last %0d,",
                  " want kind %0d page %0d pid %0d last %0d"},
                 what, $time, got.kind, got.page, got.pid, got.last,
                 want.kind, want.page, want.pid, want.last);
    endtask

    function automatic word_t mk_word(input logic [1:0] k,
                                      input logic [lrupl_pkg::PAGE_W-1:0] pg,
                                      input logic [lrupl_pkg::PID_W-1:0] pd,
                                      input logic lst);
        word_t w;
        w.kind = k;
        w.page = pg;
        w.pid  = pd;
        w.last = lst;
        return w;
    endfunction

    // apply one accepted command to the model and queue the words it yields
    function automatic void predict_words(input logic [1:0] c_op,
                                          input logic [lrupl_pkg::PAGE_W-1:0] c_pg,
                                          input logic [lrupl_pkg::PID_W-1:0] c_pd);
        logic [lrupl_pkg::PAGE_W-1:0] kept[$];
        int                           n_cleared;
        int                           idx[$];
        n_cleared = 0;
        case (c_op)
            lrupl_pkg::OP_TOUCH:
            begin
                // move to front, or insert at the front when absent
                idx = recency_q.find_first_index(x) with (x == c_pg);
                if (idx.size() != 0)
                    recency_q.delete(idx[0]);
                recency_q.push_front(c_pg);
                owner_of[c_pg] = c_pd;
                pending_words.push_back(mk_word(lrupl_pkg::KIND_DONE, '0, '0, 1'b1));
            end
            lrupl_pkg::OP_REMOVE:
            begin
                // walk from most recent, clearing every page of this pid
                foreach (recency_q[i])
                begin
                    if (owner_of[recency_q[i]] == c_pd)
                    begin
                        pending_words.push_back(mk_word(lrupl_pkg::KIND_CLEARED,
                                                        recency_q[i], c_pd, 1'b0));
                        n_cleared++;
                    end
                    else
                        kept.push_back(recency_q[i]);
                end
                recency_q = kept;
                if (n_cleared == 0)
                    pending_words.push_back(mk_word(lrupl_pkg::KIND_DONE, '0, '0, 1'b1));
                else
                    pending_words[pending_words.size()-1].last = 1'b1;
            end
            default:
            begin
                // peek and evict both report the tail; evict drops it
                if (recency_q.size() == 0)
                    pending_words.push_back(mk_word(lrupl_pkg::KIND_EMPTY, '0, '0, 1'b1));
                else
                begin
                    pending_words.push_back(mk_word(lrupl_pkg::KIND_LRU, recency_q[$],
                                                    owner_of[recency_q[$]], 1'b1));
                    if (c_op == lrupl_pkg::OP_EVICT)
                        void'(recency_q.pop_back());
                end
            end
        endcase
    endfunction

    // send one command: an optional random gap with start low, then hold start until an accepting edge;
    // start is left high so a following command can be presented at once
    task automatic send_cmd(input logic [1:0] c_op,
                            input logic [lrupl_pkg::PAGE_W-1:0] c_pg,
                            input logic [lrupl_pkg::PID_W-1:0] c_pd, input bit may_idle);
        if (may_idle)
        begin
            while ($urandom_range(99) < 37)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        op    <= c_op;
        page  <= c_pg;
        pid   <= c_pd;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // the edge just taken accepted the command
        predict_words(c_op, c_pg, c_pd);
    endtask

    // result checker: every strobe is compared with the oldest expected word
    always @(posedge clk)
    begin
        word_t got;
        word_t want;
        if (rst_n && strobe)
        begin
            got = mk_word(kind, out_page, out_pid, last);
            if (pending_words.size() == 0)
                report_mismatch("unexpected word", got, got);
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                    report_mismatch("result word", got, want);
            end
        end
    end

    // watchdog: cycles with no accepted command and no result word
    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [1:0] rand_op();
        int r;
        r = $urandom_range(99);
        // touches dominate so the list fills and removes have work to do
        if (r < 55)
            return lrupl_pkg::OP_TOUCH;
        else if (r < 70)
            return lrupl_pkg::OP_REMOVE;
        else if (r < 85)
            return lrupl_pkg::OP_PEEK;
        else
            return lrupl_pkg::OP_EVICT;
    endfunction

    initial
    begin
        logic [1:0]                  r_op;
        logic [lrupl_pkg::PID_W-1:0] r_pd;
        bit                          calm;
        int                          wait_cnt;

        err_count   = 0;
        idle_cycles = 0;
        timed_out   = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        op    = lrupl_pkg::OP_TOUCH;
        page  = '0;
        pid   = '0;

        // directed table: empty list, extremes of page and pid, every op
        directed = '{
            '{lrupl_pkg::OP_PEEK,   5'd0,  8'd0,   1'b1, lrupl_pkg::KIND_EMPTY},
            '{lrupl_pkg::OP_EVICT,  5'd0,  8'd0,   1'b1, lrupl_pkg::KIND_EMPTY},
            '{lrupl_pkg::OP_REMOVE, 5'd0,  8'd7,   1'b1, lrupl_pkg::KIND_DONE},
            '{lrupl_pkg::OP_TOUCH,  5'd0,  8'd0,   1'b1, lrupl_pkg::KIND_DONE},
            '{lrupl_pkg::OP_TOUCH,  5'd31, 8'd255, 1'b1, lrupl_pkg::KIND_DONE},
            '{lrupl_pkg::OP_TOUCH,  5'd10, 8'd255, 1'b1, lrupl_pkg::KIND_DONE},
            '{lrupl_pkg::OP_TOUCH,  5'd21, 8'd170, 1'b1, lrupl_pkg::KIND_DONE},
            '{lrupl_pkg::OP_TOUCH,  5'd5,  8'd85,  1'b1, lrupl_pkg::KIND_DONE},
            '{lrupl_pkg::OP_PEEK,   5'd0,  8'd0,   1'b0, lrupl_pkg::KIND_LRU},
            '{lrupl_pkg::OP_TOUCH,  5'd0,  8'd85,  1'b1, lrupl_pkg::KIND_DONE},
            '{lrupl_pkg::OP_TOUCH,  5'd5,  8'd85,  1'b1, lrupl_pkg::KIND_DONE},
            '{lrupl_pkg::OP_PEEK,   5'd31, 8'd255, 1'b0, lrupl_pkg::KIND_LRU},
            '{lrupl_pkg::OP_TOUCH,  5'd31, 8'd255, 1'b1, lrupl_pkg::KIND_DONE},
            '{lrupl_pkg::OP_REMOVE, 5'd0,  8'd255, 1'b0, lrupl_pkg::KIND_CLEARED},
            '{lrupl_pkg::OP_REMOVE, 5'd0,  8'd1,   1'b1, lrupl_pkg::KIND_DONE},
            '{lrupl_pkg::OP_EVICT,  5'd0,  8'd0,   1'b0, lrupl_pkg::KIND_LRU},
            '{lrupl_pkg::OP_TOUCH,  5'd21, 8'd0,   1'b1, lrupl_pkg::KIND_DONE},
            '{lrupl_pkg::OP_REMOVE, 5'd0,  8'd85,  1'b0, lrupl_pkg::KIND_CLEARED},
            '{lrupl_pkg::OP_EVICT,  5'd0,  8'd0,   1'b0, lrupl_pkg::KIND_LRU},
            '{lrupl_pkg::OP_EVICT,  5'd0,  8'd0,   1'b1, lrupl_pkg::KIND_EMPTY},
            '{lrupl_pkg::OP_PEEK,   5'd0,  8'd0,   1'b1, lrupl_pkg::KIND_EMPTY},
            '{lrupl_pkg::OP_REMOVE, 5'd0,  8'd0,   1'b1, lrupl_pkg::KIND_DONE}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_cmd(directed[i].op, directed[i].page, directed[i].pid, 1'b1);
            // typed-in kind where it is plain from the table; full word via the model
            if (directed[i].chk_kind &&
                pending_words[pending_words.size()-1].kind !== directed[i].exp_kind)
                report_mismatch("directed row", pending_words[pending_words.size()-1],
                                mk_word(directed[i].exp_kind, '0, '0, 1'b1));
        end

        // hold off until the list has emptied its result backlog
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);

        // random part: few pids so removes clear several pages at once
        for (int n = 0; n < 165; n++)
        begin
            calm = (n >= 80 && n < 120);
            r_op = rand_op();
            if ($urandom_range(9) < 8)
                r_pd = 8'($urandom_range(3));
            else
                r_pd = 8'($urandom_range(255));
            // once, at n == 150, fill every slot with pages of pid 0 or 1, then remove pid 0
            if (n == 150)
            begin
                for (int p = 0; p < lrupl_pkg::MAX_SLOTS; p++)
                    send_cmd(lrupl_pkg::OP_TOUCH, lrupl_pkg::PAGE_W'(p),
                             8'($urandom_range(1)), 1'b0);
                send_cmd(lrupl_pkg::OP_REMOVE, '0, 8'd0, 1'b0);
            end
            send_cmd(r_op, lrupl_pkg::PAGE_W'($urandom_range(31)), r_pd, !calm);
        end
        start <= 1'b0;

        wait_cnt = 0;
        while (pending_words.size() != 0 && wait_cnt < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (lrupl_pkg::MAX_SLOTS + 4) @(posedge clk);

        if (err_count == 0 && pending_words.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/lrupl_pkg.sv
sv/lru_page_replacement_list.sv
tb/tb_top.sv
